@@ rtl/drle_pkg.sv @@
// Shared types and constants of the direction run-length text encoder.
`timescale 1ns / 1ps
`default_nettype none
package drle_pkg;

  localparam int unsigned CmdBytes = 9;
  localparam int unsigned CntW     = $clog2(CmdBytes + 1);

  localparam logic [5:0] WrapReset = 6'd60;

  typedef enum logic [1:0] {
    OpTick   = 2'd0,
    OpFlush  = 2'd1,
    OpRandom = 2'd2,
    OpEog    = 2'd3
  } drle_op_e;

  typedef enum logic [2:0] {
    DirRight = 3'd0,
    DirUp    = 3'd1,
    DirLeft  = 3'd2,
    DirDown  = 3'd3,
    DirNone  = 3'd4
  } drle_dir_e;

  localparam logic [7:0] ChR  = 8'h72;
  localparam logic [7:0] ChU  = 8'h75;
  localparam logic [7:0] ChL  = 8'h6C;
  localparam logic [7:0] ChD  = 8'h64;
  localparam logic [7:0] ChS  = 8'h73;
  localparam logic [7:0] ChE  = 8'h45;
  localparam logic [7:0] ChO  = 8'h4F;
  localparam logic [7:0] ChLu = 8'h4C;
  localparam logic [7:0] ChG  = 8'h47;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] CaseOffset = 8'd32;

  // One queued piece of text: bytes in emission order, byte 0 first.
  typedef struct packed {
    logic [CmdBytes-1:0][7:0] text;
    logic [CntW-1:0]          count;
  } drle_cmd_t;

  typedef struct packed {
    logic      valid;
    drle_cmd_t cmd;
  } drle_push_t;

endpackage
`default_nettype wire

@@ rtl/drle_if.sv @@
// Channel interfaces: input items, configuration writes and output bytes.
`timescale 1ns / 1ps
`default_nettype none
interface drle_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [2:0]  direction;
  logic        fire;
  logic [31:0] random_value;

  modport source (output valid, operation, direction, fire, random_value, input ready);
  modport sink   (input valid, operation, direction, fire, random_value, output ready);
endinterface

interface drle_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] line_wrap_column;

  modport source (output valid, line_wrap_column, input ready);
  modport sink   (input valid, line_wrap_column, output ready);
endinterface

interface drle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, text_byte, last_byte, input ready);
  modport sink   (input valid, text_byte, last_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/drle_front.sv @@
// Front end: accepts items, tracks the run and column, builds the text to emit.
`timescale 1ns / 1ps
`default_nettype none
module drle_front import drle_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  drle_in_if.sink     in_i,
  drle_cfg_if.sink    cfg_i,
  input  wire         full_i,
  output drle_push_t  push_o
);

  logic [5:0]       wrap_q;
  logic [7:0]       sym_q, sym_d;
  logic [2:0][3:0]  dig_q, dig_d;   // run length in BCD, hundreds first
  logic [6:0]       col_q, col_d;
  logic             accept;

  function automatic logic [7:0] symbol_of(logic [2:0] dir, logic fire);
    logic [7:0] c;
    unique case (drle_dir_e'(dir))
      DirRight: c = ChR;
      DirUp:    c = ChU;
      DirLeft:  c = ChL;
      DirDown:  c = ChD;
      default:  c = ChS;
    endcase
    return fire ? (c - CaseOffset) : c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    return (v < 4'd10) ? {4'h3, v} : ({4'h0, v} + 8'h37);
  endfunction

  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;

  always_comb begin
    logic [7:0]          sym_new;
    logic                len_zero, len_one, len_max;
    logic [2:0][3:0]     dig_inc;
    logic [1:0]          ndig;
    logic [7:0]          col_sum;
    logic                wrap_hit;
    logic [6:0]          col_run;
    logic [6:0]          col_mid;
    logic                do_run;
    logic [CmdBytes-1:0][7:0] text;
    logic [CntW-1:0]     n;

    sym_new  = symbol_of(in_i.direction, in_i.fire);
    len_zero = (dig_q == '0);
    len_one  = (dig_q == {4'd0, 4'd0, 4'd1});
    len_max  = (dig_q == {4'd9, 4'd9, 4'd9});

    // BCD increment with ripple carry
    dig_inc = dig_q;
    if (dig_q[0] != 4'd9) begin
      dig_inc[0] = dig_q[0] + 4'd1;
    end else begin
      dig_inc[0] = 4'd0;
      if (dig_q[1] != 4'd9) begin
        dig_inc[1] = dig_q[1] + 4'd1;
      end else begin
        dig_inc[1] = 4'd0;
        dig_inc[2] = dig_q[2] + 4'd1;
      end
    end

    if (len_one)                ndig = 2'd0;
    else if (dig_q[2] != 4'd0)  ndig = 2'd3;
    else if (dig_q[1] != 4'd0)  ndig = 2'd2;
    else                        ndig = 2'd1;

    col_sum  = {1'b0, col_q} + 8'd1 + {6'd0, ndig};
    wrap_hit = (col_sum >= {2'b00, wrap_q});
    col_run  = wrap_hit ? 7'd0 : col_sum[6:0];

    sym_d  = sym_q;
    dig_d  = dig_q;
    col_d  = col_q;
    do_run = 1'b0;
    text   = '0;
    n      = '0;

    unique case (drle_op_e'(in_i.operation))
      OpTick: begin
        if (len_zero) begin
          sym_d = sym_new;
          dig_d = {4'd0, 4'd0, 4'd1};
        end else if ((sym_q != sym_new) || len_max) begin
          do_run = 1'b1;
          sym_d  = sym_new;
          dig_d  = {4'd0, 4'd0, 4'd1};
          col_d  = col_run;
        end else begin
          dig_d = dig_inc;
        end
      end
      OpFlush: begin
        do_run = !len_zero;
        sym_d  = '0;
        dig_d  = '0;
        col_d  = '0;
      end
      OpRandom: begin
        dig_d = '0;
        col_d = '0;
      end
      default: ;
    endcase

    // Pending run: symbol, count without leading zeros, optional wrap newline
    if (do_run) begin
      text[n] = sym_q;
      n = n + 1'b1;
      if (!len_one) begin
        if (dig_q[2] != 4'd0) begin
          text[n] = {4'h3, dig_q[2]};
          n = n + 1'b1;
        end
        if ((dig_q[2] != 4'd0) || (dig_q[1] != 4'd0)) begin
          text[n] = {4'h3, dig_q[1]};
          n = n + 1'b1;
        end
        text[n] = {4'h3, dig_q[0]};
        n = n + 1'b1;
      end
      if (wrap_hit) begin
        text[n] = ChLf;
        n = n + 1'b1;
      end
    end

    col_mid = do_run ? col_run : col_q;

    unique case (drle_op_e'(in_i.operation))
      OpFlush: begin
        if (col_mid != 7'd0) begin
          text[n] = ChLf;
          n = n + 1'b1;
        end
        text[n] = ChE;  n = n + 1'b1;
        text[n] = ChO;  n = n + 1'b1;
        text[n] = ChLu; n = n + 1'b1;
        text[n] = ChLf; n = n + 1'b1;
      end
      OpRandom: begin
        for (int i = 0; i < 8; i++) begin
          text[i] = hex_char(in_i.random_value[(7 - i) * 4 +: 4]);
        end
        text[8] = ChLf;
        n = CntW'(CmdBytes);
      end
      OpEog: begin
        text[0] = ChE;
        text[1] = ChO;
        text[2] = ChG;
        text[3] = ChLf;
        n = CntW'(4);
      end
      default: ;
    endcase

    push_o.valid     = accept && (n != '0);
    push_o.cmd.text  = text;
    push_o.cmd.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= WrapReset;
      sym_q  <= '0;
      dig_q  <= '0;
      col_q  <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        wrap_q <= cfg_i.line_wrap_column;
      end
      if (accept) begin
        sym_q <= sym_d;
        dig_q <= dig_d;
        col_q <= col_d;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/drle_cmd_fifo.sv @@
// Two-entry queue of text pieces between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module drle_cmd_fifo import drle_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  drle_push_t  push_i,
  output logic        full_o,
  input  wire         pop_i,
  output drle_cmd_t   head_o,
  output logic        empty_o
);

  drle_cmd_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

@@ rtl/drle_back.sv @@
// Back end: shifts queued text out one byte per cycle, while the output is not stalled, through an output register.
`timescale 1ns / 1ps
`default_nettype none
module drle_back import drle_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  drle_cmd_t   head_i,
  input  wire         empty_i,
  output logic        pop_o,
  drle_out_if.source  out_o
);

  logic [CmdBytes-1:0][7:0] text_q;
  logic [CntW-1:0]          rem_q;
  logic                     busy_q;
  logic                     vld_q;
  logic [7:0]               byte_q;
  logic                     last_q;
  logic                     adv, emit, is_last;

  assign adv     = !vld_q || out_o.ready;
  assign emit    = adv && busy_q;
  assign is_last = (rem_q == CntW'(1));
  assign pop_o   = !empty_i && (!busy_q || (emit && is_last));

  assign out_o.valid     = vld_q;
  assign out_o.text_byte = byte_q;
  assign out_o.last_byte = last_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      text_q <= head_i.text;
      rem_q  <= head_i.count;
    end else if (emit) begin
      // advance to the next byte
      text_q <= {8'h00, text_q[CmdBytes-1:1]};
      rem_q  <= rem_q - 1'b1;
    end
    if (adv) begin
      byte_q <= text_q[0];
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (emit && is_last) begin
        busy_q <= 1'b0;
      end
      if (adv) begin
        vld_q <= busy_q;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/direction_run_length_text_encoder_core.sv @@
// Top level of the direction run-length text encoder.
// An accepted item's text is registered in the queue, then in the back end's shift
// register, then in the output register. Each item produces up to nine bytes, sent one
// byte per cycle while the output is ready; an item that produces no byte is not queued.
// Reset: run and column cleared, wrap column set to 60, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none
module direction_run_length_text_encoder_core import drle_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  drle_in_if.sink     in_i,
  drle_cfg_if.sink    cfg_i,
  drle_out_if.source  out_o
);

  drle_push_t push;
  drle_cmd_t  head;
  logic       full, empty, pop;

  drle_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push)
  );

  drle_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  drle_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the direction run-length text encoder core.
`timescale 1ns / 1ps
module tb_top;
  import drle_pkg::*;

  localparam int          CycleLimit = 500000;
  localparam int          MaxRun     = 999;
  localparam int          DrainWait  = 12;
  localparam logic [7:0]  ChZero     = 8'h30;
  localparam logic [7:0]  ChHexA     = 8'h41;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } text_char_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  drle_in_if  in_if ();
  drle_cfg_if cfg_if ();
  drle_out_if out_if ();

  direction_run_length_text_encoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Encoder state mirrored in the testbench
  logic [7:0] enc_sym;
  logic [9:0] enc_len;
  logic [6:0] enc_col;
  logic [5:0] enc_wrap;

  logic [7:0] item_chars [$];
  text_char_t awaited_chars [$];
  text_char_t seen_char;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int err_count;
  int cycle_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Append the pending run: symbol, count when above one, newline at the wrap column.
  function automatic void write_run();
    item_chars.push_back(enc_sym);
    enc_col++;
    if (enc_len > 10'd1) begin
      if (enc_len >= 10'd100) begin
        item_chars.push_back(ChZero + 8'(enc_len / 100));
        enc_col++;
      end
      if (enc_len >= 10'd10) begin
        item_chars.push_back(ChZero + 8'((enc_len / 10) % 10));
        enc_col++;
      end
      item_chars.push_back(ChZero + 8'(enc_len % 10));
      enc_col++;
    end
    if (enc_col >= {1'b0, enc_wrap}) begin
      item_chars.push_back(ChLf);
      enc_col = '0;
    end
  endfunction

  function automatic void encode_item(drle_op_e op, logic [2:0] dir, logic fire,
                                      logic [31:0] word);
    logic [7:0] sym;
    logic [3:0] nib;
    int         n;
    item_chars.delete();
    case (op)
      OpTick: begin
        case (dir)
          DirRight: sym = ChR;
          DirUp:    sym = ChU;
          DirLeft:  sym = ChL;
          DirDown:  sym = ChD;
          default:  sym = ChS;
        endcase
        if (fire) sym = sym - CaseOffset;
        if (enc_len == '0) enc_sym = sym;
        if (enc_sym != sym) begin
          write_run();
          enc_sym = sym;
          enc_len = 10'd1;
        end else begin
          if (enc_len >= 10'(MaxRun)) begin
            write_run();
            enc_len = '0;
          end
          enc_len++;
        end
      end
      OpFlush: begin
        if (enc_len != '0) write_run();
        if (enc_col != '0) item_chars.push_back(ChLf);
        item_chars.push_back(ChE);
        item_chars.push_back(ChO);
        item_chars.push_back(ChLu);
        item_chars.push_back(ChLf);
        enc_sym = '0;
        enc_len = '0;
        enc_col = '0;
      end
      OpRandom: begin
        for (int i = 7; i >= 0; i--) begin
          nib = word[i*4 +: 4];
          item_chars.push_back(nib < 4'd10 ? ChZero + 8'(nib) : ChHexA + 8'(nib - 4'd10));
        end
        item_chars.push_back(ChLf);
        // drop the pending run unwritten, symbol stays
        enc_len = '0;
        enc_col = '0;
      end
      default: begin
        item_chars.push_back(ChE);
        item_chars.push_back(ChO);
        item_chars.push_back(ChG);
        item_chars.push_back(ChLf);
      end
    endcase
    n = (item_chars.size() > int'(CmdBytes)) ? int'(CmdBytes) : item_chars.size();
    for (int k = 0; k < n; k++) begin
      awaited_chars.push_back('{text_byte: item_chars[k], last_byte: (k == n - 1)});
    end
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance with valid still high.
  task automatic send_item(drle_op_e op, logic [2:0] dir, logic fire, logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= op;
    in_if.direction    <= dir;
    in_if.fire         <= fire;
    in_if.random_value <= word;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    encode_item(op, dir, fire, word);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (awaited_chars.size() != 0) @(negedge clk_i);
    // ticks that emit nothing may still be in flight
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_wrap(logic [5:0] value);
    drain();
    cfg_if.valid            <= 1'b1;
    cfg_if.line_wrap_column <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    enc_wrap = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_symbols();
    for (int d = 0; d < 8; d++) begin
      for (int f = 0; f < 2; f++) begin
        send_item(OpTick, 3'(d), 1'(f), $urandom());
      end
    end
    send_item(OpFlush, DirNone, 1'b0, $urandom());
  endtask

  task automatic test_ops();
    send_item(OpFlush, DirRight, 1'b1, 32'h0);
    send_item(OpRandom, DirNone, 1'b0, 32'h0000_0000);
    send_item(OpRandom, DirNone, 1'b0, 32'hFFFF_FFFF);
    send_item(OpRandom, DirNone, 1'b0, 32'h0123_4567);
    send_item(OpRandom, DirNone, 1'b0, 32'h89AB_CDEF);
    send_item(OpEog, 3'd7, 1'b1, $urandom());
    repeat (5) send_item(OpTick, DirUp, 1'b0, $urandom());
    send_item(OpRandom, DirUp, 1'b0, $urandom());
    repeat (2) send_item(OpTick, DirUp, 1'b0, $urandom());
    send_item(OpEog, DirNone, 1'b0, $urandom());
    send_item(OpFlush, DirNone, 1'b0, $urandom());
  endtask

  task automatic test_wrap_extremes();
    write_wrap(6'd0);
    for (int i = 0; i < 8; i++) send_item(OpTick, 3'(i % 3), 1'b0, $urandom());
    send_item(OpFlush, DirNone, 1'b0, $urandom());
    write_wrap(6'd63);
    // single-tick runs fill a line one column at a time
    for (int i = 0; i < 140; i++) send_item(OpTick, 3'(i % 5), 1'((i / 5) % 2), $urandom());
    send_item(OpFlush, DirNone, 1'b0, $urandom());
  endtask

  task automatic test_run_limit();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // close the run at the limit, then start a run of one
    repeat (MaxRun + 1) send_item(OpTick, DirDown, 1'b1, $urandom());
    send_item(OpTick, 3'd6, 1'b0, $urandom());
    send_item(OpFlush, DirNone, 1'b0, $urandom());
  endtask

  task automatic test_backpressure();
    drain();
    send_idle_pct = 0;
    @(posedge clk_i);
    hold_cycles = 300;
    @(negedge clk_i);
    for (int i = 0; i < 40; i++) begin
      case (i % 4)
        0: send_item(OpRandom, DirNone, 1'b0, $urandom());
        1: send_item(OpEog, DirNone, 1'b0, $urandom());
        2: send_item(OpTick, 3'($urandom_range(4)), 1'($urandom_range(1)), $urandom());
        default: send_item(OpFlush, DirNone, 1'b0, $urandom());
      endcase
    end
    drain();
  endtask

  task automatic run_random(int n_items);
    int         sent;
    int         len;
    int         pick;
    logic [2:0] dir;
    logic       fire;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      dir  = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      fire = 1'($urandom_range(1));
      if (pick < 75) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(120, 20) : $urandom_range(1, 5);
        repeat (len) send_item(OpTick, dir, fire, $urandom());
        sent += len;
      end else begin
        if (pick < 85)      send_item(OpFlush, dir, fire, $urandom());
        else if (pick < 93) send_item(OpRandom, dir, fire, $urandom());
        else                send_item(OpEog, dir, fire, $urandom());
        sent++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited_chars.size() == 0) begin
        $error("text_byte: nothing expected, got %h", out_if.text_byte);
        err_count++;
      end else begin
        seen_char = awaited_chars.pop_front();
        if (out_if.text_byte !== seen_char.text_byte) begin
          $error("text_byte: expected %h, got %h", seen_char.text_byte, out_if.text_byte);
          err_count++;
        end
        if (out_if.last_byte !== seen_char.last_byte) begin
          $error("last_byte: expected %b, got %b", seen_char.last_byte, out_if.last_byte);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni                  = 1'b0;
    in_if.valid             = 1'b0;
    in_if.operation         = OpTick;
    in_if.direction         = DirNone;
    in_if.fire              = 1'b0;
    in_if.random_value      = '0;
    cfg_if.valid            = 1'b0;
    cfg_if.line_wrap_column = '0;
    out_if.ready            = 1'b0;
    hold_cycles             = 0;
    err_count               = 0;
    cycle_count             = 0;
    send_idle_pct           = 28;
    recv_idle_pct           = 87;
    enc_sym                 = '0;
    enc_len                 = '0;
    enc_col                 = '0;
    enc_wrap                = WrapReset;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_symbols();
    test_ops();
    test_wrap_extremes();
    test_run_limit();

    send_idle_pct = 28;
    recv_idle_pct = 87;
    write_wrap(6'd8);
    run_random(150);
    test_backpressure();

    send_idle_pct = 87;
    recv_idle_pct = 28;
    write_wrap(6'($urandom_range(59, 9)));
    run_random(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_wrap(6'd60);
    run_random(150);

    drain();
    repeat (20) @(negedge clk_i);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
